>>> src/uart_rfm_pkg.sv
// Package for the UART register frame master: protocol bytes, status codes, result kinds.
package uart_rfm_pkg;

  // Frame bytes of the register protocol
  localparam logic [7:0] STX_BYTE   = 8'h02;
  localparam logic [7:0] OP_WRITE   = 8'h37;
  localparam logic [7:0] OP_READ    = 8'h38;
  localparam logic [7:0] READ_COUNT = 8'h01;
  localparam logic [7:0] ACK_BYTE   = 8'h06;
  localparam logic [7:0] NACK_BYTE  = 8'h15;
  localparam logic [7:0] ACK_LEN    = 8'd4;

  // Longest request frame in bytes
  localparam int FRAME_BYTES = 7;
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  // Input kind (tuser of the input stream)
  typedef enum logic {
    FUNC_CMD = 1'b0,
    FUNC_RX  = 1'b1
  } func_t;

  // Result kind (tuser of the output stream)
  typedef enum logic {
    KIND_TX     = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  // Response status codes
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NACK     = 3'd1,
    ST_BAD_ACK  = 3'd2,
    ST_CHECKSUM = 3'd3,
    ST_OVERLONG = 3'd4
  } status_t;

endpackage

>>> src/uart_register_frame_master.sv
// UART register frame master: builds request frames and checks response frames.
//
// Input stream (s_*): one transfer is either a register command (tuser = 0) or one
// received response byte (tuser = 1, tlast marks the last byte of the response).
// Output stream (m_*): transmit bytes (tuser = 0, tlast on the checksum byte) or a
// response status (tuser = 1) carrying the status code and the read value.
//
// A command builds its whole frame combinationally into a seven-byte shift buffer;
// the first byte is valid the cycle after the input transfer and the frame then
// leaves one byte per output transfer: 5 bytes for a read, 6 or 7 for a write.
// The next input item is taken in the same cycle as the last byte of the frame,
// so a new command is taken as the previous frame ends, paced by the single output
// byte port. Response bytes update the receive sum and count at the input transfer;
// the last one loads a status into the output register, valid in the next cycle, and
// with a ready receiver response bytes flow at one per cycle.
//
// Reset empties the output buffer by clearing its count and clears the receive
// state and the pending command kind. When the receiver holds m_tready low the
// current byte or status stays on the port and s_tready drops until the buffer drains.
module uart_register_frame_master #(
  parameter int MAX_FRAME = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // is_write, reg_addr[7:0], reg_data[15:0], data_len[1:0],
                                 // rx_byte[7:0], zero fill
  input  logic        s_tuser,   // func
  input  logic        s_tlast,   // rx_last
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // tx_byte[7:0], status[2:0], read_value[7:0], zero fill
  output logic        m_tuser,   // out_kind
  output logic        m_tlast    // tx_last
);
  import uart_rfm_pkg::*;

  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME);

  // Input fields
  logic        in_is_write;
  logic [7:0]  in_addr;
  logic [15:0] in_data;
  logic [1:0]  in_len;
  logic [7:0]  in_rx_byte;
  logic        in_take;

  assign in_is_write = s_tdata[0];
  assign in_addr     = s_tdata[8:1];
  assign in_data     = s_tdata[24:9];
  assign in_len      = s_tdata[26:25];
  assign in_rx_byte  = s_tdata[34:27];

  // Output buffer and receive state
  logic [7:0]       frame_buf [FRAME_BYTES];
  logic [CNT_W-1:0] cnt;
  kind_t            kind;
  status_t          st;
  logic [7:0]       read_value;

  logic             pending_is_write;
  logic [6:0]       rx_count;
  logic [7:0]       rx_sum;
  logic [7:0]       rx_third_byte;

  // Handshake
  logic finishing;
  assign finishing = m_tvalid && m_tready && (cnt == CNT_W'(1));
  assign s_tready  = (cnt == '0) || finishing;
  assign in_take   = s_tvalid && s_tready;

  // Frame or status built from the accepted item
  logic [7:0]       new_bytes [FRAME_BYTES];
  logic [CNT_W-1:0] new_cnt;
  kind_t            new_kind;
  status_t          new_st;
  logic [7:0]       new_rv;
  logic             new_out;
  logic [1:0]       wr_len;
  logic [7:0]       sum;
  logic [7:0]       eff_third;
  logic [7:0]       rx_len;

  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      new_bytes[i] = '0;
    end
    new_cnt  = '0;
    new_kind = KIND_TX;
    new_st   = ST_OK;
    new_rv   = '0;
    new_out  = 1'b0;
    wr_len   = (in_len == 2'd0) ? 2'd1 : ((in_len == 2'd3) ? 2'd2 : in_len);
    sum      = '0;
    eff_third = (rx_count == 7'd2) ? in_rx_byte : rx_third_byte;
    rx_len    = {1'b0, rx_count} + 8'd1;

    if (s_tuser == FUNC_CMD) begin
      new_out      = 1'b1;
      new_bytes[0] = STX_BYTE;
      new_bytes[2] = in_addr;
      if (in_is_write) begin
        new_bytes[1] = OP_WRITE;
        new_bytes[3] = {6'd0, wr_len};
        new_bytes[4] = in_data[7:0];
        if (wr_len == 2'd2) begin
          new_bytes[5] = in_data[15:8];
          sum = STX_BYTE + OP_WRITE + in_addr + {6'd0, wr_len} + in_data[7:0]
                + in_data[15:8];
          new_bytes[6] = sum;
          new_cnt = CNT_W'(7);
        end else begin
          sum = STX_BYTE + OP_WRITE + in_addr + {6'd0, wr_len} + in_data[7:0];
          new_bytes[5] = sum;
          new_cnt = CNT_W'(6);
        end
      end else begin
        new_bytes[1] = OP_READ;
        new_bytes[3] = READ_COUNT;
        sum = STX_BYTE + OP_READ + in_addr + READ_COUNT;
        new_bytes[4] = sum;
        new_cnt = CNT_W'(5);
      end
    end else if (s_tlast) begin
      // Status decision on the last response byte, first match wins
      new_out  = 1'b1;
      new_kind = KIND_STATUS;
      new_cnt  = CNT_W'(1);
      new_rv   = (rx_len >= 8'd3) ? eff_third : 8'd0;
      if (rx_len > MAX_LEN) begin
        new_st = ST_OVERLONG;
      end else if (rx_sum != in_rx_byte) begin
        new_st = ST_CHECKSUM;
      end else if (rx_len < 8'd3) begin
        new_st = ST_BAD_ACK;
      end else if (!pending_is_write) begin
        new_st = ST_OK;
      end else if (eff_third == NACK_BYTE) begin
        new_st = ST_NACK;
      end else if (eff_third != ACK_BYTE || rx_len != ACK_LEN) begin
        new_st = ST_BAD_ACK;
      end else begin
        new_st = ST_OK;
      end
    end
  end

  // Output buffer: load on an item with results, shift on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (in_take && new_out) begin
      cnt <= new_cnt;
    end else if (m_tvalid && m_tready) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && new_out) begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
        frame_buf[i] <= new_bytes[i];
      end
      kind       <= new_kind;
      st         <= new_st;
      read_value <= new_rv;
    end else if (m_tvalid && m_tready) begin
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
        frame_buf[i] <= frame_buf[i+1];
      end
      frame_buf[FRAME_BYTES-1] <= '0;
    end
  end

  // Receive state and pending command kind
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_is_write <= 1'b0;
      rx_count         <= '0;
      rx_sum           <= '0;
      rx_third_byte    <= '0;
    end else if (in_take) begin
      if (s_tuser == FUNC_CMD) begin
        pending_is_write <= in_is_write;
        rx_count         <= '0;
        rx_sum           <= '0;
        rx_third_byte    <= '0;
      end else if (s_tlast) begin
        rx_count      <= '0;
        rx_sum        <= '0;
        rx_third_byte <= '0;
      end else begin
        if (rx_count == 7'd2) begin
          rx_third_byte <= in_rx_byte;
        end
        rx_sum <= rx_sum + in_rx_byte;
        if (rx_count != 7'd127) begin
          rx_count <= rx_count + 7'd1;
        end
      end
    end
  end

  // Output port
  assign m_tvalid = (cnt != '0);
  assign m_tuser  = kind;
  assign m_tlast  = (kind == KIND_TX) && (cnt == CNT_W'(1));
  assign m_tdata  = {5'd0, read_value, st, frame_buf[0]};

  // A status is always a single result
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (cnt == CNT_W'(1)))
    else $error("status result with bytes still queued");

  // Checksum byte only marked on transmit results
  a_last_tx: assert property (@(posedge clk) disable iff (rst)
    m_tlast |-> (m_tvalid && !m_tuser))
    else $error("tlast on a non-transmit result");

  // An empty buffer never blocks input
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // A frame keeps going after a byte that is not the last
  a_frame_cont: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tuser && !m_tlast) |=> (m_tvalid && !m_tuser))
    else $error("request frame cut short");

  // Status results carry no transmit byte
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[7:0] == 8'd0))
    else $error("status result with nonzero tx byte");

endmodule
